[rtl/mvspm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mvspm_pkg;
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_PLAY  = 2'd2,
		FUNC_STOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_READ,
		BK_MUL1,
		BK_MUL2,
		BK_MASTER,
		BK_OUT
	} bk_state_t;

	localparam logic [15:0] GAIN_MAX = 16'd49152;
	localparam logic [15:0] GAIN_RESET = 16'd32768;
	localparam logic [16:0] UNITY = 17'd32768;

	typedef struct packed {
		func_t       func;
		logic [15:0] address;
		logic [15:0] sample_value;
		logic [16:0] length;
		logic [15:0] voice_volume;
		logic [15:0] pan;
		logic [7:0]  track;
		logic        mono;
	} item_t;

	typedef struct packed {
		logic [15:0] left_out;
		logic [15:0] right_out;
		status_t     status;
		logic [4:0]  live_voices;
	} result_t;
endpackage
`default_nettype wire

[rtl/mvspm_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface mvspm_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/mvspm_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Accepts items into a two-entry queue in front of the execution engine.
module mvspm_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	mvspm_if.sink                in_ch,
	output mvspm_pkg::item_t     q_data,
	output logic                 q_valid,
	input  wire logic            q_pop
);
	mvspm_pkg::item_t mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

[rtl/mvspm_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Executes one item at a time: sample writes, voice table updates, and the
// per-slot mixing walk for a tick.
module mvspm_back #(
	parameter int MAX_VOICES = 16,
	parameter int SAMPLE_WORDS = 65536
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [15:0]   cfg_data,
	input  mvspm_pkg::item_t   q_data,
	input  wire logic          q_valid,
	output logic               q_pop,
	mvspm_if.source            out_ch
);
	localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int AW = $clog2(SAMPLE_WORDS);
	localparam int CW = $clog2(MAX_VOICES + 1);

	logic [15:0] store_q [SAMPLE_WORDS];
	logic [15:0] rdata_q;
	logic [AW-1:0] raddr;

	logic [MAX_VOICES-1:0] live_q;
	logic [15:0] start_q  [MAX_VOICES];
	logic [16:0] len_q    [MAX_VOICES];
	logic [16:0] cur_q    [MAX_VOICES];
	logic [15:0] gain_q   [MAX_VOICES];
	logic [15:0] pan_q    [MAX_VOICES];
	logic [7:0]  track_q  [MAX_VOICES];

	logic [15:0] master_q;
	mvspm_pkg::bk_state_t st_q, st_d;
	logic [VW-1:0] idx_q;
	logic signed [39:0] lsum_q, rsum_q;
	logic signed [32:0] lt_q, rt_q;
	logic signed [56:0] lm_q, rm_q;
	logic out_valid_q;
	mvspm_pkg::result_t res_q;

	mvspm_pkg::func_t fn;
	assign fn = q_data.func;

	// Slot selection for play/stop, and the live count for every result.
	logic [MAX_VOICES-1:0] kill_mask, after_kill;
	logic                  found;
	logic [VW-1:0]         free_idx;
	logic [CW-1:0]         live_cnt;
	always_comb begin
		for (int i = 0; i < MAX_VOICES; i++)
			kill_mask[i] = live_q[i] && (track_q[i] == q_data.track);
		after_kill = live_q;
		if (fn == mvspm_pkg::FUNC_STOP ||
		    (q_data.mono && q_data.track != 8'd0))
			after_kill = live_q & ~kill_mask;
		found = 1'b0;
		free_idx = '0;
		for (int i = MAX_VOICES - 1; i >= 0; i--)
			if (!after_kill[i]) begin
				found = 1'b1;
				free_idx = VW'(i);
			end
		live_cnt = '0;
		for (int i = 0; i < MAX_VOICES; i++)
			live_cnt = live_cnt + CW'(live_q[i]);
	end

	mvspm_pkg::status_t play_status;
	always_comb begin
		play_status = mvspm_pkg::ST_DONE;
		if (fn == mvspm_pkg::FUNC_PLAY) begin
			if (q_data.length == 17'd0) play_status = mvspm_pkg::ST_ZERO;
			else if (!found) play_status = mvspm_pkg::ST_FULL;
		end
	end

	logic idx_last;
	assign idx_last = (idx_q == VW'(MAX_VOICES - 1));
	logic cur_done;
	assign cur_done = cur_q[idx_q] >= len_q[idx_q];
	logic [16:0] addr_sum;
	assign addr_sum = {1'b0, start_q[idx_q]} + cur_q[idx_q];
	// The queue head may already hold the next item during a tick walk.
	assign raddr = (st_q == mvspm_pkg::BK_IDLE) ? AW'(q_data.address) : AW'(addr_sum);

	always_ff @(posedge clk) begin
		if (st_q == mvspm_pkg::BK_IDLE && q_valid && !out_valid_q &&
		    fn == mvspm_pkg::FUNC_WRITE)
			store_q[raddr] <= q_data.sample_value;
		rdata_q <= store_q[raddr];
	end

	// Pan products computed from registered sample.
	logic signed [16:0] sx, lp, rp, pn;
	assign sx = {rdata_q[15], rdata_q};
	assign pn = {pan_q[idx_q][15], pan_q[idx_q]};
	assign lp = pn[16] || pn == 17'sd0 ? signed'(mvspm_pkg::UNITY) :
		signed'(mvspm_pkg::UNITY) - pn;
	assign rp = !pn[16] ? signed'(mvspm_pkg::UNITY) : signed'(mvspm_pkg::UNITY) + pn;
	logic signed [33:0] lprod, rprod;
	assign lprod = sx * lp;
	assign rprod = sx * rp;
	logic signed [16:0] gx;
	assign gx = {1'b0, gain_q[idx_q]};
	logic signed [49:0] lg, rg;
	assign lg = lt_q * gx;
	assign rg = rt_q * gx;
	logic signed [16:0] mx;
	assign mx = {1'b0, master_q};
	logic signed [56:0] lmp, rmp;
	assign lmp = lsum_q * mx;
	assign rmp = rsum_q * mx;

	function automatic logic [15:0] sat(input logic signed [56:0] v);
		if (v > 57'sd32767) return 16'h7FFF;
		if (v < -57'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		unique case (st_q)
			mvspm_pkg::BK_IDLE: begin
				if (q_valid && !out_valid_q) begin
					q_pop = 1'b1;
					if (fn == mvspm_pkg::FUNC_TICK) st_d = mvspm_pkg::BK_SCAN;
				end
			end
			mvspm_pkg::BK_SCAN: begin
				if (live_q[idx_q] && !cur_done) st_d = mvspm_pkg::BK_READ;
				else if (idx_last) st_d = mvspm_pkg::BK_MASTER;
			end
			mvspm_pkg::BK_READ: st_d = mvspm_pkg::BK_MUL1;
			mvspm_pkg::BK_MUL1: st_d = mvspm_pkg::BK_MUL2;
			mvspm_pkg::BK_MUL2:
				st_d = idx_last ? mvspm_pkg::BK_MASTER : mvspm_pkg::BK_SCAN;
			mvspm_pkg::BK_MASTER: st_d = mvspm_pkg::BK_OUT;
			mvspm_pkg::BK_OUT: st_d = mvspm_pkg::BK_IDLE;
			default: st_d = mvspm_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			mvspm_pkg::BK_MUL1: begin
				lt_q <= 33'(lprod >>> 15);
				rt_q <= 33'(rprod >>> 15);
			end
			mvspm_pkg::BK_MUL2: begin
				lsum_q <= lsum_q + 40'(lg >>> 15);
				rsum_q <= rsum_q + 40'(rg >>> 15);
			end
			mvspm_pkg::BK_MASTER: begin
				lm_q <= lmp >>> 15;
				rm_q <= rmp >>> 15;
			end
			mvspm_pkg::BK_IDLE: begin
				lsum_q <= '0;
				rsum_q <= '0;
			end
			default: ;
		endcase
		if (st_q == mvspm_pkg::BK_IDLE && q_valid && !out_valid_q &&
		    fn == mvspm_pkg::FUNC_PLAY && q_data.length != 17'd0 && found) begin
			start_q[free_idx] <= q_data.address;
			len_q[free_idx] <= q_data.length;
			cur_q[free_idx] <= '0;
			gain_q[free_idx] <= q_data.voice_volume;
			pan_q[free_idx] <= q_data.pan;
			track_q[free_idx] <= q_data.track;
		end
		if (st_q == mvspm_pkg::BK_READ) cur_q[idx_q] <= cur_q[idx_q] + 17'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mvspm_pkg::BK_IDLE;
			master_q <= mvspm_pkg::GAIN_RESET;
			live_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_we)
				master_q <= (cfg_data > mvspm_pkg::GAIN_MAX) ? mvspm_pkg::GAIN_MAX : cfg_data;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			unique case (st_q)
				mvspm_pkg::BK_IDLE: begin
					idx_q <= '0;
					if (q_valid && !out_valid_q && fn != mvspm_pkg::FUNC_TICK) begin
						res_q <= '{left_out: '0, right_out: '0, status: play_status,
							live_voices: '0};
						out_valid_q <= 1'b1;
						if (fn == mvspm_pkg::FUNC_STOP) begin
							live_q <= after_kill;
						end else if (fn == mvspm_pkg::FUNC_PLAY &&
						             q_data.length != 17'd0) begin
							live_q <= after_kill | (found ?
								(MAX_VOICES'(1) << free_idx) : '0);
						end
					end
				end
				mvspm_pkg::BK_SCAN: begin
					if (live_q[idx_q] && cur_done) live_q[idx_q] <= 1'b0;
					if (!(live_q[idx_q] && !cur_done) && !idx_last) idx_q <= idx_q + VW'(1);
				end
				mvspm_pkg::BK_MUL2: if (!idx_last) idx_q <= idx_q + VW'(1);
				mvspm_pkg::BK_OUT: begin
					res_q <= '{left_out: sat(lm_q), right_out: sat(rm_q),
						status: mvspm_pkg::ST_DONE, live_voices: '0};
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Live count is taken from the table as it stands when the result shows.
	always_comb begin
		out_ch.data = res_q;
		out_ch.data.live_voices = 5'(live_cnt);
	end
	assign out_ch.valid = out_valid_q;
endmodule
`default_nettype wire

[rtl/multi_voice_stereo_pan_mixer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload
// in_ch    in   mvspm_pkg::item_t (func .. mono)
// out_ch   out  mvspm_pkg::result_t (left_out, right_out, status, live_voices)
// cfg      in   master_gain write (cfg_we, cfg_data)
// Write, play and stop are taken from idle; a tick walks every slot in order, skipping
// idle slots and taking each live slot through read and two multiply states, as the
// walk goes through the single sample memory port and shared multipliers.
// Reset clears the voice table and sets master gain to unity.
// A two-entry queue holds input while a result waits to be taken.
module multi_voice_stereo_pan_mixer_core #(
	parameter int MAX_VOICES = 16,
	parameter int SAMPLE_WORDS = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	mvspm_if.sink            in_ch,
	mvspm_if.source          out_ch
);
	mvspm_pkg::item_t q_data;
	logic q_valid, q_pop;

	mvspm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
	);

	mvspm_back #(.MAX_VOICES(MAX_VOICES), .SAMPLE_WORDS(SAMPLE_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.q_data(q_data), .q_valid(q_valid), .q_pop(q_pop), .out_ch(out_ch)
	);
endmodule
`default_nettype wire

[rtl/mvspm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module mvspm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [4:0]  live_voices,
	input wire logic [15:0] left_out
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> live_voices <= 5'd16) else $error("live count");
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> left_out == 16'd0) else $error("mix on play");
endmodule

bind multi_voice_stereo_pan_mixer_core mvspm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.data.status), .live_voices(out_ch.data.live_voices),
	.left_out(out_ch.data.left_out)
);
`default_nettype wire

[sim/mvspm_checker.sv]
`timescale 1ns / 1ps
module mvspm_scoreboard (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_data,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire mvspm_pkg::item_t in_data,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire mvspm_pkg::result_t out_data,
	output int                    fail_count,
	output int                    pending_frames,
	output int                    tick_count,
	output int                    play_count
);
	import mvspm_pkg::*;

	logic signed [15:0] sample_mem [int];
	logic        voice_live [16];
	logic [15:0] voice_start [16];
	logic [16:0] voice_len [16];
	logic [16:0] voice_cursor [16];
	logic [15:0] voice_gain [16];
	logic signed [15:0] voice_pan [16];
	logic [7:0]  voice_track [16];
	logic [15:0] master;
	result_t     expected_mix [$];

	// Arithmetic shift on a signed value is the floor shift the mixer uses.
	function automatic longint q15(longint v);
		return v >>> 15;
	endfunction

	function automatic logic [16:0] sat16(longint v);
		if (v > 32767) return 17'(32767);
		if (v < -32768) return 17'h18000;
		return 17'(v);
	endfunction

	function automatic logic [4:0] live_total();
		logic [4:0] n;
		n = 0;
		for (int i = 0; i < 16; i++) n += voice_live[i];
		return n;
	endfunction

	task automatic free_track(logic [7:0] trk);
		for (int i = 0; i < 16; i++)
			if (voice_live[i] && voice_track[i] == trk) voice_live[i] = 0;
	endtask

	task automatic mix_item(item_t it);
		result_t r;
		longint lsum, rsum, s, lp, rp, t;
		int slot;
		logic [15:0] a;
		r = '0;
		case (it.func)
			FUNC_TICK: begin
				lsum = 0;
				rsum = 0;
				for (int i = 0; i < 16; i++) begin
					if (!voice_live[i]) continue;
					if (voice_cursor[i] >= voice_len[i]) begin
						voice_live[i] = 0;
						continue;
					end
					a = 16'(voice_start[i] + voice_cursor[i]);
					s = sample_mem.exists(a) ? longint'(sample_mem[a]) : 0;
					voice_cursor[i]++;
					lp = voice_pan[i] <= 0 ? 32768 : 32768 - longint'(voice_pan[i]);
					rp = voice_pan[i] >= 0 ? 32768 : 32768 + longint'(voice_pan[i]);
					t = q15(s * lp);
					lsum += q15(t * longint'(voice_gain[i]));
					t = q15(s * rp);
					rsum += q15(t * longint'(voice_gain[i]));
				end
				r.left_out = 16'(sat16(q15(lsum * longint'(master))));
				r.right_out = 16'(sat16(q15(rsum * longint'(master))));
			end
			FUNC_WRITE: sample_mem[it.address] = $signed(it.sample_value);
			FUNC_PLAY: begin
				if (it.length == 0) begin
					r.status = ST_ZERO;
				end else begin
					slot = -1;
					if (it.mono && it.track != 0) free_track(it.track);
					for (int i = 0; i < 16; i++)
						if (!voice_live[i] && slot < 0) slot = i;
					if (slot < 0) begin
						r.status = ST_FULL;
					end else begin
						voice_live[slot] = 1;
						voice_start[slot] = it.address;
						voice_len[slot] = it.length;
						voice_cursor[slot] = 0;
						voice_gain[slot] = it.voice_volume;
						voice_pan[slot] = $signed(it.pan);
						voice_track[slot] = it.track;
					end
				end
			end
			default: free_track(it.track);
		endcase
		r.live_voices = live_total();
		expected_mix.insert(expected_mix.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) voice_live[i] = 0;
			master = GAIN_RESET;
			expected_mix.delete();
			fail_count = 0;
			tick_count = 0;
			play_count = 0;
		end else begin
			if (cfg_we) master = cfg_data > GAIN_MAX ? GAIN_MAX : cfg_data;
			if (out_valid && out_ready) begin
				if (expected_mix.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					fail_count++;
				end else begin
					e = expected_mix.pop_front();
					if (e.left_out != out_data.left_out
						|| e.right_out != out_data.right_out
						|| e.status != out_data.status
						|| e.live_voices != out_data.live_voices) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.func == FUNC_TICK) tick_count++;
				if (in_data.func == FUNC_PLAY) play_count++;
				mix_item(in_data);
			end
		end
		pending_frames = expected_mix.size();
	end
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
	import mvspm_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_data;
	int fail_count, pending_frames, tick_count, play_count;
	int send_idle_pct, recv_stall_pct, hold_cycles, quiet_cycles, accepted;
	bit done;

	mvspm_if #(.T(item_t)) in_ch ();
	mvspm_if #(.T(result_t)) out_ch ();

	multi_voice_stereo_pan_mixer_core DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	mvspm_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.fail_count(fail_count), .pending_frames(pending_frames),
		.tick_count(tick_count), .play_count(play_count)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off when hold_cycles is set.
	initial begin
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 0;
				hold_cycles--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles > 20000) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Valid stays high after a transfer so items can follow back to back;
	// it drops when the sender idles or drains.
	task automatic send(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		accepted++;
		@(negedge clk);
	endtask

	function automatic item_t blank(func_t f);
		item_t it;
		it = '0;
		it.func = f;
		it.address = 16'($urandom);
		it.sample_value = 16'($urandom);
		it.voice_volume = 16'($urandom);
		it.pan = 16'($urandom);
		it.track = 8'($urandom);
		it.mono = 1'($urandom);
		return it;
	endfunction

	task automatic write_word(logic [15:0] a, logic [15:0] v);
		item_t it;
		it = blank(FUNC_WRITE);
		it.address = a;
		it.sample_value = v;
		send(it);
	endtask

	// Plays only over written words: a run of written addresses starting at base.
	task automatic play(logic [15:0] base, logic [16:0] len, logic [7:0] trk,
		logic m, logic [15:0] vol, logic [15:0] pn);
		item_t it;
		it = blank(FUNC_PLAY);
		it.address = base;
		it.length = len;
		it.track = trk;
		it.mono = m;
		it.voice_volume = vol;
		it.pan = pn;
		send(it);
	endtask

	task automatic tick();
		send(blank(FUNC_TICK));
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (pending_frames != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_gain(logic [15:0] g);
		@(negedge clk);
		cfg_we <= 1;
		cfg_data <= g;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_item();
		int r;
		item_t it;
		r = $urandom_range(99);
		if (r < 45) begin
			tick();
		end else if (r < 65) begin
			write_word(16'($urandom_range(0, 511)), 16'($urandom));
		end else if (r < 90) begin
			// Start inside the written block so every read stays in written words.
			play(16'($urandom_range(0, 255)), 17'($urandom_range(1, 256)),
				8'($urandom_range(0, 5)), 1'($urandom), 16'($urandom), 16'($urandom));
		end else if (r < 93) begin
			it = blank(FUNC_PLAY);
			it.length = 0;
			send(it);
		end else begin
			it = blank(FUNC_STOP);
			it.track = 8'($urandom_range(0, 5));
			send(it);
		end
	endtask

	initial begin
		logic [15:0] gains [5];
		gains = '{16'd32768, 16'd0, 16'd49152, 16'd65535, 16'd12345};
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		accepted = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Fill the first 512 words; long voices wrap around through address 0.
		for (int a = 0; a < 512; a++)
			write_word(16'(a), a == 0 ? 16'h8000 : a == 1 ? 16'h7FFF : 16'($urandom));
		write_word(16'd65534, 16'($urandom));
		write_word(16'd65535, 16'($urandom));

		// Directed: extremes, pan ends, wrap, zero length, mono, stop track 0, full table.
		tick();
		play(16'd0, 17'd2, 8'd0, 0, 16'hFFFF, 16'h8000);
		play(16'd0, 17'd2, 8'd0, 0, 16'hFFFF, 16'h7FFF);
		play(16'd65534, 17'd4, 8'd1, 0, 16'd32768, 16'd0);
		play(16'd1, 17'd0, 8'd1, 1, 16'd1, 16'd1);
		tick(); tick(); tick(); tick(); tick();
		for (int i = 0; i < 18; i++)
			play(16'(i), 17'd65536, 8'(i % 3), 0, 16'hFFFF, 16'(i * 4000));
		play(16'd3, 17'd5, 8'd1, 1, 16'd100, 16'hFFFF);
		tick();
		begin
			item_t st;
			st = blank(FUNC_STOP);
			st.track = 0;
			send(st);
			st.track = 2;
			send(st);
		end
		tick();
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			set_gain(gains[ph]);
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 69; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 69; end
				3: begin send_idle_pct = 36; recv_stall_pct = 36; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			if (ph == 4) hold_cycles = 400;
			for (int n = 0; n < 120; n++) random_item();
			drain();
			// Stop every voice so the next phase starts from an empty table.
			for (int t = 0; t < 6; t++) begin
				item_t st;
				st = blank(FUNC_STOP);
				st.track = 8'(t);
				send(st);
			end
			drain();
		end

		$display("Covered %0d items: %0d ticks, %0d plays, five master gain settings.",
			accepted, tick_count, play_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
